// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, status codes and the control bundle for the cell row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int COUNT_W = 4;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic ins_en;
    logic del_en;
  } spq_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps up to DEPTH signed priorities in descending order in a row of cells.
// ----------------------------------------------------------------------------
// A request beat is taken at a rising edge with start high and busy low; func
// selects insert or delete of value. The row of cells shifts at the accepting
// edge, and in the following cycle done is high for exactly one cycle with
// status, count, top_valid and top_value. One request can be accepted in every
// cycle, since every cell decides its new entry from its own compare and that
// of its neighbor nearer the head. busy therefore stays low.
// An insert into a full queue, a delete from an empty queue and a delete that
// finds no equal entry leave the entries unchanged and report it in status.
// Equal priorities: an insert goes ahead of stored equal values and a delete
// removes the one nearest the head.
// Reset clears the fill count and done; stored entries are not cleared, as
// only entries below the fill count are ever read. The receiver cannot stall:
// each result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int DEPTH       = 8,
  parameter int VALUE_WIDTH = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  output logic                               busy,
  input  wire                                func,
  input  wire  signed [VALUE_WIDTH-1:0]       value,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [spq_pkg::COUNT_W-1:0]        count,
  output logic                               top_valid,
  output logic signed [VALUE_WIDTH-1:0]       top_value
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                cnt;
  logic [CW-1:0]                cnt_next;
  logic [1:0]                   status_next;
  logic                         accept;
  logic                         full;
  logic                         found;
  spq_ctl_t                     ctl;
  logic signed [VALUE_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]             valid;
  logic [DEPTH-1:0]             ge;
  logic [DEPTH-1:0]             le;
  logic [DEPTH-1:0]             eq;
  logic [CW+COUNT_W-1:0]        cnt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt == CW'(DEPTH));
  assign found  = |eq;

  always_comb begin
    ctl.ins_en  = accept && (func == FUNC_INSERT) && !full;
    ctl.del_en  = accept && (func == FUNC_DELETE) && found;
    cnt_next    = cnt;
    status_next = ST_DONE;
    if (func == FUNC_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cnt_next = cnt + 1'b1;
      end
    end else begin
      if (cnt == '0) begin
        status_next = ST_EMPTY;
      end else if (!found) begin
        status_next = ST_NOTFOUND;
      end else begin
        cnt_next = cnt - 1'b1;
      end
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    assign valid[k] = (CW'(k) < cnt);
    spq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .req_value (value),
      .valid     (valid[k]),
      .prev_ge   ((k == 0) ? 1'b0 : ge[(k == 0) ? 0 : k - 1]),
      .prev_entry((k == 0) ? '0 : entry[(k == 0) ? 0 : k - 1]),
      .next_entry((k == DEPTH - 1) ? '0 : entry[(k == DEPTH - 1) ? k : k + 1]),
      .entry     (entry[k]),
      .ge        (ge[k]),
      .le        (le[k]),
      .eq        (eq[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        cnt    <= cnt_next;
        status <= status_next;
      end
    end
  end

  assign cnt_ext   = (CW + COUNT_W)'(cnt);
  assign count     = cnt_ext[COUNT_W-1:0];
  assign top_valid = (cnt != '0);
  assign top_value = top_valid ? entry[0] : '0;

endmodule
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the request value and takes the request
// value or a neighbor's entry when the row shifts on an insert or a delete.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire                          clk,
  input  spq_pkg::spq_ctl_t            ctl,
  input  wire  signed [VALUE_WIDTH-1:0] req_value,
  input  wire                          valid,
  input  wire                          prev_ge,
  input  wire  signed [VALUE_WIDTH-1:0] prev_entry,
  input  wire  signed [VALUE_WIDTH-1:0] next_entry,
  output logic signed [VALUE_WIDTH-1:0] entry,
  output logic                         ge,
  output logic                         le,
  output logic                         eq
);
  import spq_pkg::*;

  // The row is sorted in descending order, so ge is monotone along it and le is monotone over the valid entries.
  assign ge = !valid || (req_value >= entry);
  assign le = valid && (entry <= req_value);
  assign eq = valid && (entry == req_value);

  always_ff @(posedge clk) begin
    if (ctl.ins_en) begin
      if (prev_ge) begin
        entry <= prev_entry;
      end else if (ge) begin
        entry <= req_value;
      end
    end else if (ctl.del_en) begin
      if (le) begin
        entry <= next_entry;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the ports of the queue for result beats that are missing, spurious
// or inconsistent with the reported count.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int VALUE_WIDTH = 16
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               start,
  input wire                               busy,
  input wire                               done,
  input wire [1:0]                         status,
  input wire [spq_pkg::COUNT_W-1:0]        count,
  input wire                               top_valid,
  input wire [VALUE_WIDTH-1:0]             top_value
);
  import spq_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request beat not answered in the next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result beat without a request");

  a_top_valid: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_valid == (count != '0)))
    else $error("top_valid disagrees with count");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (done && !top_valid) |-> (top_value == '0))
    else $error("top_value not zero on an empty queue");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> (count == '0))
    else $error("empty status with entries held");

endmodule

bind sorted_priority_queue spq_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .count    (count),
  .top_valid(top_valid),
  .top_value(top_value)
);
`default_nettype wire

// ===== sim/queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches the request and result channels of the queue. Keeps its own sorted
// copy of the stored priorities, works out the reply to every accepted request
// beat and compares each result beat, field by field, with the oldest
// outstanding reply. Mismatches and unexpected result beats are counted.
// ----------------------------------------------------------------------------
module queue_checker #(
  parameter int DEPTH   = 8,
  parameter int VALUE_W = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                start,
  input  wire                                busy,
  input  wire                                func,
  input  wire  signed [VALUE_W-1:0]          value,
  input  wire                                done,
  input  wire  [1:0]                         status,
  input  wire  [spq_pkg::COUNT_W-1:0]        count,
  input  wire                                top_valid,
  input  wire  signed [VALUE_W-1:0]          top_value,
  output int                                 fail_count,
  output int                                 pending
);
  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]                 status;
    logic [COUNT_W-1:0]         count;
    logic                       top_valid;
    logic signed [VALUE_W-1:0]  top_value;
  } queue_reply_t;

  logic signed [VALUE_W-1:0] held [DEPTH];
  int unsigned               held_count;
  queue_reply_t              expected_replies [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    held_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] queue_checker: %s", $time, msg);
    fail_count++;
  endtask

  function automatic queue_reply_t apply_request(input logic f,
                                                 input logic signed [VALUE_W-1:0] v);
    queue_reply_t reply;
    int unsigned  pos;
    bit           found;
    reply.status = ST_DONE;
    if (f == FUNC_INSERT) begin
      if (held_count >= DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        pos = held_count;
        for (int k = int'(held_count) - 1; k >= 0; k--) begin
          if (v >= held[k]) pos = k;
        end
        for (int k = held_count; k > int'(pos); k--) held[k] = held[k-1];
        held[pos] = v;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        reply.status = ST_EMPTY;
      end else begin
        found = 1'b0;
        for (int k = 0; k < int'(held_count); k++) begin
          if (!found && held[k] == v) begin
            found = 1'b1;
            pos   = k;
          end
        end
        if (found) begin
          for (int k = pos; k + 1 < int'(held_count); k++) held[k] = held[k+1];
          held_count--;
        end else begin
          reply.status = ST_NOTFOUND;
        end
      end
    end
    reply.count     = held_count[COUNT_W-1:0];
    reply.top_valid = (held_count != 0);
    reply.top_value = (held_count != 0) ? held[0] : '0;
    return reply;
  endfunction

  always @(posedge clk) begin
    queue_reply_t want;
    if (rst) begin
      held_count = 0;
      expected_replies.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d", want.status, status));
          if (count !== want.count)
            report_mismatch($sformatf("count expected %0d got %0d", want.count, count));
          if (top_valid !== want.top_valid)
            report_mismatch($sformatf("top_valid expected %0d got %0d",
                                      want.top_valid, top_valid));
          if (top_value !== want.top_value)
            report_mismatch($sformatf("top_value expected %0d got %0d",
                                      want.top_value, top_value));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_replies.push_back(apply_request(func, value));
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and delete request beats into the queue: a directed sequence
// over the value extremes, equal priorities, full, empty and not-found cases,
// then random traffic in three phases of sender idling. The checker beside the
// block predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int DEPTH          = 8;
  localparam int VALUE_W        = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 510;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        func;
  logic signed [VALUE_W-1:0]   value;
  wire                         busy;
  wire                         done;
  wire  [1:0]                  status;
  wire  [COUNT_W-1:0]          count;
  wire                         top_valid;
  wire  signed [VALUE_W-1:0]   top_value;

  int fail_count;
  int pending;
  int stall_cycles = 0;
  int sender_idle_pct;
  int insert_pct;
  logic signed [VALUE_W-1:0] recent_values [$];

  sorted_priority_queue #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_W)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .value(value),
    .done(done), .status(status), .count(count), .top_valid(top_valid),
    .top_value(top_value)
  );

  queue_checker #(.DEPTH(DEPTH), .VALUE_W(VALUE_W)) u_queue_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func), .value(value),
    .done(done), .status(status), .count(count), .top_valid(top_valid),
    .top_value(top_value), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic issue(input logic f, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      func  <= 1'($urandom_range(1));
      value <= VALUE_W'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    func  <= f;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (f == FUNC_INSERT) begin
      recent_values.push_back(v);
      if (recent_values.size() > 12) void'(recent_values.pop_front());
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input logic for_delete);
    if (recent_values.size() != 0 && (for_delete && $urandom_range(1) == 1))
      return recent_values[$urandom_range(recent_values.size() - 1)];
    case ($urandom_range(3))
      0: return VALUE_W'($urandom);
      1: return VALUE_W'($urandom_range(8)) - VALUE_W'(4);
      2: begin
        case ($urandom_range(3))
          0: return {1'b0, {(VALUE_W-1){1'b1}}};
          1: return {1'b1, {(VALUE_W-1){1'b0}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: begin
        if (recent_values.size() == 0) return VALUE_W'($urandom);
        return recent_values[$urandom_range(recent_values.size() - 1)];
      end
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) insert_pct = 25 * $urandom_range(1, 3);
      if ($urandom_range(99) < insert_pct) begin
        issue(FUNC_INSERT, pick_value(1'b0));
      end else begin
        issue(FUNC_DELETE, pick_value(1'b1));
      end
    end
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    func            = FUNC_INSERT;
    value           = '0;
    sender_idle_pct = 31;
    insert_pct      = 50;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(FUNC_DELETE, 16'sd0);
    issue(FUNC_INSERT, 16'sd0);
    issue(FUNC_INSERT, -16'sd32768);
    issue(FUNC_INSERT, 16'sd32767);
    issue(FUNC_INSERT, 16'sd5);
    issue(FUNC_INSERT, 16'sd5);
    issue(FUNC_INSERT, -16'sd1);
    issue(FUNC_INSERT, 16'sd1);
    issue(FUNC_INSERT, -16'sd32768);
    issue(FUNC_INSERT, 16'sd100);
    issue(FUNC_DELETE, 16'sd42);
    issue(FUNC_DELETE, 16'sd32767);
    issue(FUNC_DELETE, -16'sd32768);
    issue(FUNC_DELETE, 16'sd5);
    issue(FUNC_INSERT, 16'sd5);
    issue(FUNC_DELETE, 16'sd5);
    issue(FUNC_DELETE, 16'sd5);
    issue(FUNC_DELETE, 16'sd0);
    issue(FUNC_DELETE, -16'sd1);
    issue(FUNC_DELETE, 16'sd1);
    issue(FUNC_DELETE, -16'sd32768);
    issue(FUNC_DELETE, -16'sd32768);
    issue(FUNC_INSERT, -16'sd1);
    issue(FUNC_DELETE, -16'sd1);

    run_random(PHASE_ITEMS);
    sender_idle_pct = 63;
    run_random(PHASE_ITEMS);
    sender_idle_pct = 0;
    run_random(PHASE_ITEMS);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
